>>> rtl/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

  // Field widths fixed by the stream format
  localparam int PrioW     = 32;
  localparam int ItemW     = 32;
  localparam int CountOutW = 9;

  // Operation selector carried on the input tuser bit
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One heap entry: priority in the high half, payload in the low half
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [ItemW-1:0] item;
  } entry_t;

  // Operation request from the stream front end to the heap engine
  typedef struct packed {
    logic   valid;
    logic   mode;
    entry_t entry;
  } req_t;

  // Finished operation from the heap engine
  typedef struct packed {
    logic                 valid;
    logic [ItemW-1:0]     item;
    status_e              status;
    logic                 is_empty;
    logic [CountOutW-1:0] count;
  } res_t;

endpackage

>>> rtl/bmhq_core.sv
`timescale 1ns / 1ps

module bmhq_core import bmhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  output logic ready_o,
  output res_t res_o,
  input  logic res_take_i
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_RD    = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_ROOT = 9'b000001000,
    S_POP_LAST = 9'b000010000,
    S_DN_RDL   = 9'b000100000,
    S_DN_RDR   = 9'b001000000,
    S_DN_CMPR  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  entry_t           key_q, key_d;
  entry_t           best_q, best_d;
  logic             best_left_q, best_left_d;
  logic [ItemW-1:0] res_item_q, res_item_d;
  status_e          res_status_q, res_status_d;

  // Heap storage, one write and one registered read per cycle
  entry_t        mem_q [CAPACITY];
  entry_t        rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Child and parent indexes of the current hole
  logic [XW-1:0] left_x, right_x, count_x;
  logic          has_l, has_r;
  logic [AW-1:0] parent;

  assign left_x  = {1'b0, pos_q, 1'b1};
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count_q);
  assign has_l   = left_x < count_x;
  assign has_r   = right_x < count_x;
  assign parent  = (pos_q - AW'(1)) >> 1;

  // Shared priority comparator: cmp_lt = a < b
  logic [PrioW-1:0] cmp_a, cmp_b;
  logic             cmp_lt;

  always_comb begin
    if (state_q == S_UP_CMP) begin
      cmp_a = key_q.prio;
      cmp_b = rd_data_q.prio;
    end else if (state_q == S_DN_RDR) begin
      cmp_a = rd_data_q.prio;
      cmp_b = key_q.prio;
    end else begin
      cmp_a = rd_data_q.prio;
      cmp_b = best_q.prio;
    end
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer: sift with a hole, the moving entry is written once at the end
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    key_d        = key_q;
    best_d       = best_q;
    best_left_d  = best_left_q;
    res_item_d   = res_item_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_data      = key_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_item_d   = '0;
          res_status_d = ST_OK;
          if (req_i.mode == MODE_PUSH) begin
            if (count_q >= CW'(CAPACITY)) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              key_d   = req_i.entry;
              pos_d   = AW'(count_q);
              state_d = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_POP_ROOT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          wr_data = rd_data_q;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end
      end

      S_POP_ROOT: begin
        res_item_d = rd_data_q.item;
        rd_en      = 1'b1;
        rd_addr    = AW'(count_q - CW'(1));
        count_d    = count_q - CW'(1);
        state_d    = S_POP_LAST;
      end

      S_POP_LAST: begin
        key_d   = rd_data_q;
        pos_d   = '0;
        state_d = (count_q == '0) ? S_DONE : S_DN_RDL;
      end

      S_DN_RDL: begin
        if (has_l) begin
          rd_en   = 1'b1;
          rd_addr = left_x[AW-1:0];
          state_d = S_DN_RDR;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end

      S_DN_RDR: begin
        best_d      = cmp_lt ? rd_data_q : key_q;
        best_left_d = cmp_lt;
        if (has_r) begin
          rd_en   = 1'b1;
          rd_addr = right_x[AW-1:0];
          state_d = S_DN_CMPR;
        end else if (cmp_lt) begin
          wr_en   = 1'b1;
          wr_data = rd_data_q;
          pos_d   = left_x[AW-1:0];
          state_d = S_DN_RDL;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end

      S_DN_CMPR: begin
        wr_en = 1'b1;
        // right wins only below both the key and the left child
        if (cmp_lt) begin
          wr_data = rd_data_q;
          pos_d   = right_x[AW-1:0];
          state_d = S_DN_RDL;
        end else if (best_left_q) begin
          wr_data = best_q;
          pos_d   = left_x[AW-1:0];
          state_d = S_DN_RDL;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    key_q        <= key_d;
    best_q       <= best_d;
    best_left_q  <= best_left_d;
    res_item_q   <= res_item_d;
    res_status_q <= res_status_d;
  end

  assign ready_o        = (state_q == S_IDLE);
  assign res_o.valid    = (state_q == S_DONE);
  assign res_o.item     = res_item_q;
  assign res_o.status   = res_status_q;
  assign res_o.is_empty = (count_q == '0);
  assign res_o.count    = CountOutW'(count_q);

endmodule

>>> rtl/binary_min_heap_queue_top.sv
`timescale 1ns / 1ps

// Min-heap priority queue of (priority, payload) entries, CAPACITY deep.
// Input stream: one beat per operation. tuser selects push (0) or pop (1);
// tdata carries the payload and priority of a push (ignored on a pop).
// Output stream: exactly one result beat per operation, in order, with the
// popped payload (0 on push or failure), a status code, an empty flag and
// the entry count after the operation.
// Operations run one at a time on a single-port-write, single-read heap
// memory with one shared priority comparator. A push climbs one level at
// a time, reading the parent and comparing it with the new entry; a pop
// reads the root and then the last entry, which it sinks one level at a
// time, reading the left and then the right child.
// A rejected push or an empty pop goes straight to the done state. The
// result waits there for the output register. Input tready is high while
// the engine is idle, so a new operation is taken while a previous result
// still waits in the output register; if the receiver stalls further, the
// engine holds its finished result and input tready stays low.
// Reset empties the heap at once; no clearing pass is needed.

module binary_min_heap_queue_top import bmhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] item_in, [63:32] priority_in
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [31:0] item_out, [33:32] status,
                                      // [34] is_empty, [43:35] count_out,
                                      // [47:44] zero
);

  req_t req;
  res_t res;
  logic core_ready;
  logic res_take;

  assign req.valid      = s_axis_tvalid & core_ready;
  assign req.mode       = s_axis_tuser;
  assign req.entry.item = s_axis_tdata[31:0];
  assign req.entry.prio = s_axis_tdata[63:32];

  assign s_axis_tready = core_ready;

  bmhq_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .ready_o   (core_ready),
    .res_o     (res),
    .res_take_i(res_take)
  );

  // Output register: loads when empty or being drained this cycle
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q;

  assign res_take = res.valid & (~out_valid_q | m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= {4'b0000, res.count, res.is_empty, res.status, res.item};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // one operation at a time: an accepted beat drops tready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an operation is in flight");

  // empty pop reports an empty heap and no payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33:32] == ST_EMPTY) |->
      (m_axis_tdata[34] && m_axis_tdata[31:0] == 32'd0))
    else $error("empty pop with payload or non-empty flag");

  // a refused push never carries a payload or reports an empty heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33:32] == ST_FULL) |->
      (m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[34]))
    else $error("full push with payload or empty flag");
`endif

endmodule

>>> tb/sv/binary_min_heap_queue_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the heap queue. For each accepted input
// beat it updates a private copy of the heap and queues the result that is
// due. Each output beat is compared with the oldest due result.
module binary_min_heap_queue_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] item_in, [63:32] priority_in
  input  logic        s_axis_tuser,   // [0] mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [31:0] item_out, [33:32] status,
                                      // [34] is_empty, [43:35] count_out
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned entries_o,
  output int unsigned checked_o,
  output int unsigned full_refusals_o,
  output int unsigned empty_pops_o
);

  // One result beat as the heap should produce it
  typedef struct packed {
    logic [ItemW-1:0]     item;
    status_e              status;
    logic                 is_empty;
    logic [CountOutW-1:0] count;
  } outcome_t;

  entry_t      heap_slots [CAPACITY];
  int unsigned held;
  outcome_t    due_results [$];
  int unsigned errors;

  assign fail_count_o = errors;

  // Swap two heap slots
  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    entry_t tmp;
    tmp           = heap_slots[a];
    heap_slots[a] = heap_slots[b];
    heap_slots[b] = tmp;
  endfunction

  // Apply one push or pop to the private heap and return the due result
  function automatic outcome_t apply_heap_op(input logic mode, input entry_t ent);
    outcome_t       r;
    int unsigned    pos;
    int unsigned    par;
    int unsigned    lc;
    int unsigned    rc;
    int unsigned    nxt;
    logic [PrioW-1:0] key;
    bit             done;
    r.item   = '0;
    r.status = ST_OK;
    done     = 1'b0;
    if (mode == MODE_PUSH) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // append, then climb while the parent is strictly larger
        pos             = held;
        heap_slots[pos] = ent;
        held++;
        while (pos > 0 && !done) begin
          par = (pos - 1) / 2;
          if (heap_slots[par].prio > ent.prio) begin
            swap_slots(pos, par);
            pos = par;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // take the root, move the last entry up and sink it
      r.item        = heap_slots[0].item;
      held--;
      heap_slots[0] = heap_slots[held];
      pos           = 0;
      key           = heap_slots[0].prio;
      while (held > 0 && !done) begin
        lc  = 2 * pos + 1;
        rc  = lc + 1;
        nxt = pos;
        if (rc < held && heap_slots[rc].prio < key &&
            heap_slots[rc].prio < heap_slots[lc].prio) begin
          nxt = rc;
        end else if (lc < held && heap_slots[lc].prio < key) begin
          nxt = lc;
        end
        if (nxt == pos) begin
          done = 1'b1;
        end else begin
          swap_slots(pos, nxt);
          pos = nxt;
        end
      end
    end
    r.is_empty = (held == 0);
    r.count    = held[CountOutW-1:0];
    return r;
  endfunction

  // One line per mismatch, and count it
  task automatic log_mismatch(input string field, input logic [31:0] got,
                              input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, field, got, want);
    errors++;
  endtask

  // Track accepted beats on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t    want;
    logic [47:0] beat;
    if (!rst_ni) begin
      held = 0;
      due_results.delete();
      errors          = 0;
      pending_o       <= 0;
      entries_o       <= 0;
      checked_o       <= 0;
      full_refusals_o <= 0;
      empty_pops_o    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_heap_op(s_axis_tuser, entry_t'(s_axis_tdata));
        due_results.push_back(want);
        if (want.status == ST_FULL) full_refusals_o <= full_refusals_o + 1;
        if (want.status == ST_EMPTY) empty_pops_o <= empty_pops_o + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beat = m_axis_tdata;
        if (due_results.size() == 0) begin
          log_mismatch("result beat with nothing due", beat[31:0], '0);
        end else begin
          want = due_results.pop_front();
          if (beat[31:0] != want.item) log_mismatch("item_out", beat[31:0], want.item);
          if (beat[33:32] != want.status)
            log_mismatch("status", 32'(beat[33:32]), 32'(want.status));
          if (beat[34] != want.is_empty)
            log_mismatch("is_empty", 32'(beat[34]), 32'(want.is_empty));
          if (beat[43:35] != want.count)
            log_mismatch("count_out", 32'(beat[43:35]), 32'(want.count));
          if (beat[47:44] != '0) log_mismatch("tdata pad", 32'(beat[47:44]), '0);
        end
        checked_o <= checked_o + 1;
      end
      pending_o <= due_results.size();
      entries_o <= held;
    end
  end

endmodule

>>> tb/sv/binary_min_heap_queue_top_tb.sv
`timescale 1ns / 1ps

// Drives push and pop beats into the heap queue with random gaps and
// output stalls; the checker beside the block predicts and compares.
module binary_min_heap_queue_top_tb;
  import bmhq_pkg::*;

  localparam int Capacity = 256;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // [31:0] item_in, [63:32] priority_in
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] item_out, [33:32] status,
                                     // [34] is_empty, [43:35] count_out

  int unsigned fail_count;
  int unsigned pending;
  int unsigned entries;
  int unsigned checked;
  int unsigned full_refusals;
  int unsigned empty_pops;
  int unsigned ops_sent = 0;
  logic        steady   = 1'b0;      // no idling on either side while set

  binary_min_heap_queue_top #(.CAPACITY(Capacity)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  binary_min_heap_queue_checker #(.CAPACITY(Capacity)) heap_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .entries_o      (entries),
    .checked_o      (checked),
    .full_refusals_o(full_refusals),
    .empty_pops_o   (empty_pops)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stalls at random about 14 percent of the time unless steady
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 14);
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Priority: often from a tiny range so that ties are frequent
  function automatic logic [31:0] pick_prio();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // Offer one beat, with random gaps ahead of it, and wait for acceptance
  task automatic offer_op(input logic mode, input logic [31:0] item,
                          input logic [31:0] prio);
    while (!steady && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {prio, item};
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
  endtask

  // Random mix leaning toward pushes
  task automatic random_mix(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      offer_op(($urandom_range(0, 99) < 60) ? MODE_PUSH : MODE_POP, $urandom, pick_prio());
    end
  endtask

  // Hold the sender until every due result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned fill;
    int unsigned waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, field extremes, ties, drain past empty
    offer_op(MODE_POP,  $urandom,      $urandom);
    offer_op(MODE_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_op(MODE_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    offer_op(MODE_PUSH, 32'hA5A5_5A5A, 32'h0000_0010);
    offer_op(MODE_PUSH, 32'h0000_0001, 32'h0000_0010);
    offer_op(MODE_PUSH, 32'h0000_0002, 32'h0000_0010);
    offer_op(MODE_PUSH, 32'h0000_0003, 32'h0000_0010);
    offer_op(MODE_PUSH, 32'h5A5A_A5A5, 32'h8000_0000);
    offer_op(MODE_PUSH, 32'h8000_0000, 32'hFFFF_FFFE);
    offer_op(MODE_PUSH, 32'h7FFF_FFFF, 32'h0000_0000);
    for (int i = 0; i < 10; i++) offer_op(MODE_POP, $urandom, $urandom);
    offer_op(MODE_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    random_mix(120);

    // Fill to capacity and push past it, with no idling
    drain_results();
    steady <= 1'b1;
    fill = Capacity - entries + 3;
    for (int unsigned i = 0; i < fill; i++) offer_op(MODE_PUSH, $urandom, pick_prio());

    // Pop everything and then some
    drain_results();
    steady <= 1'b0;
    for (int i = 0; i < Capacity + 2; i++) offer_op(MODE_POP, $urandom, $urandom);

    random_mix(60);

    // Wait for the last results, then a little longer
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);

    $display("Sent %0d operations, %0d result beats checked.", ops_sent, checked);
    $display("Heap filled to %0d entries; %0d refused pushes, %0d pops on empty.",
             Capacity, full_refusals, empty_pops);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
